>>> rtl/barometric_pressure_compensation_assert.svh
// Assertion macros for the checker file of the pressure block.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// Checked at every edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define BPC_ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/bpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

    localparam int DIV_W   = 32;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 48;
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 64;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_OSS    = 2'd3;

    localparam logic [31:0] C_T_OFFSET = 32'd4000;
    localparam logic [31:0] C_HALF     = 32'd32768;
    localparam logic [31:0] C_P_SCALE  = 32'd50000;
    localparam logic [31:0] C_K1       = 32'd3038;
    localparam logic [31:0] C_K2       = 32'hFFFF_E343;
    localparam logic [31:0] C_K3       = 32'd3791;
    localparam logic [31:0] C_T_MAX    = 32'h0000_7FFF;
    localparam logic [31:0] C_T_MIN    = 32'hFFFF_8000;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage
`default_nettype wire

>>> rtl/bpc_div.sv
`timescale 1ns / 1ps
`default_nettype none
module bpc_div #(
    parameter int W  = bpc_pkg::DIV_W,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [W-1:0]  o_quo,
    output logic [PW-1:0] o_pay
);
    import bpc_pkg::*;

    // One quotient bit per stage, restoring form.
    logic [W-1:0]  r_rem [0:W-1];
    logic [W-1:0]  r_quo [0:W-1];
    logic [W-1:0]  r_den [0:W-1];
    logic [PW-1:0] r_pay [0:W-1];
    logic          r_vld [0:W-1];

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W-1:0]  a_rem;
        logic [W-1:0]  a_quo;
        logic [W-1:0]  a_den;
        logic [PW-1:0] a_pay;
        logic          a_vld;
        logic [W:0]    tr;
        logic          fit;

        if (k == 0) begin : g_first
            assign a_rem = '0;
            assign a_quo = i_num;
            assign a_den = i_den;
            assign a_pay = i_pay;
            assign a_vld = i_valid;
        end else begin : g_next
            assign a_rem = r_rem[k-1];
            assign a_quo = r_quo[k-1];
            assign a_den = r_den[k-1];
            assign a_pay = r_pay[k-1];
            assign a_vld = r_vld[k-1];
        end

        assign tr  = {a_rem, a_quo[W-1]};
        assign fit = (tr >= {1'b0, a_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fit ? W'(tr - {1'b0, a_den}) : tr[W-1:0];
                r_quo[k] <= {a_quo[W-2:0], fit};
                r_den[k] <= a_den;
                r_pay[k] <= a_pay;
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];
    assign o_pay   = r_pay[W-1];

endmodule
`default_nettype wire

>>> rtl/barometric_pressure_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  tdata                              tuser
// s_axis    in         [15:0] raw_temp, [39:16] raw_pres  none
// m_axis    out        [15:0] temp_tenths, [47:16] pa     [0] divide_error
// apb       config     64-bit registers at 0, 8, 16, 24   none
//
// One request is accepted per cycle while the output is not stalled; a request
// passes through the two 32-stage divider pipelines and the arithmetic stages.
// Reset (i_rst_n low at a clock edge) clears all valid bits and config registers.
// When the output holds an undelivered result and m_axis_tready is low, the
// whole pipeline freezes, and s_axis_tready drops in the same cycle.
module barometric_pressure_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] raw_temp, [39:16] raw_pressure_bytes
    input  logic [bpc_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] temperature_tenths, [47:16] pressure_pa
    output logic [bpc_pkg::OUT_W-1:0]     m_axis_tdata,
    // [0] divide_error
    output logic                          m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bpc_pkg::APB_W-1:0]     pwdata,
    output logic [bpc_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);
    import bpc_pkg::*;

    // Configuration registers.
    logic [63:0] r_coef_a;
    logic [63:0] r_coef_b;
    logic [31:0] r_coef_c;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_oss    <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:3])
                REG_COEF_A: r_coef_a <= pwdata;
                REG_COEF_B: r_coef_b <= pwdata;
                REG_COEF_C: r_coef_c <= pwdata[31:0];
                REG_OSS:    r_oss    <= pwdata[1:0];
                default:    r_oss    <= r_oss;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_COEF_A: prdata = r_coef_a;
            REG_COEF_B: prdata = r_coef_b;
            REG_COEF_C: prdata = {32'd0, r_coef_c};
            REG_OSS:    prdata = {62'd0, r_oss};
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // Coefficients, widened to the 32-bit working width.
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1c, b2c, mc, md;
    assign ac1 = sx16(r_coef_a[63:48]);
    assign ac2 = sx16(r_coef_a[47:32]);
    assign ac3 = sx16(r_coef_a[31:16]);
    assign ac4 = {16'd0, r_coef_a[15:0]};
    assign ac5 = {16'd0, r_coef_b[63:48]};
    assign ac6 = {16'd0, r_coef_b[47:32]};
    assign b1c = sx16(r_coef_b[31:16]);
    assign b2c = sx16(r_coef_b[15:0]);
    assign mc  = sx16(r_coef_c[31:16]);
    assign md  = sx16(r_coef_c[15:0]);

    // The whole pipeline moves together unless the output is stalled.
    logic en;
    logic r14_v;
    assign en            = !r14_v || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 0: capture and apply the oversampling shift.
    logic        r0_v;
    logic [15:0] r0_ut;
    logic [23:0] r0_up;
    // Stage 1: temperature product.
    logic        r1_v;
    logic [31:0] r1_prod;
    logic [23:0] r1_up;
    // Stage 2: signed divide operands.
    logic        r2_v;
    logic [31:0] r2_ma, r2_mb;
    logic [57:0] r2_pay;
    // Stage 3 onward.
    logic        r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v, r10_v;
    logic        r3_err, r4_err, r5_err, r6_err, r7_err, r8_err, r9_err;
    logic [15:0] r3_t, r4_t, r5_t, r6_t, r7_t, r8_t, r9_t;
    logic [23:0] r3_up, r4_up, r5_up, r6_up, r7_up;
    logic [31:0] r3_b6;
    logic [31:0] r4_b6sq, r4_ac2b6, r4_ac3b6;
    logic [31:0] r5_sq, r5_x2a, r5_x1c;
    logic [31:0] r6_b2sq, r6_b1sq, r6_x2a, r6_x1c;
    logic [31:0] r7_b3, r7_x3p;
    logic [31:0] r8_b4m, r8_diff;
    logic [31:0] r9_b4, r9_b7;
    logic [31:0] r10_num, r10_den;
    logic [17:0] r10_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (en) begin
            r0_v <= s_axis_tvalid;
            r1_v <= r0_v;
            r2_v <= r1_v;
        end
    end

    logic [31:0] s2_x1, s2_d, s2_num;
    assign s2_x1  = $unsigned($signed(r1_prod) >>> 15);
    assign s2_d   = s2_x1 + md;
    assign s2_num = mc << 11;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_ut   <= s_axis_tdata[15:0];
            r0_up   <= s_axis_tdata[39:16] >> (4'd8 - {2'd0, r_oss});
            r1_prod <= ({16'd0, r0_ut} - ac6) * ac5;
            r1_up   <= r0_up;
            r2_ma   <= s2_num[31] ? (32'd0 - s2_num) : s2_num;
            r2_mb   <= s2_d[31] ? (32'd0 - s2_d) : s2_d;
            // payload: up, zero divisor, quotient sign, x1
            r2_pay  <= {s2_x1, s2_num[31] ^ s2_d[31], (s2_d == 32'd0), r1_up};
        end
    end

    // Temperature divider: |MC << 11| / |X1 + MD|.
    logic        da_v;
    logic [31:0] da_q;
    logic [57:0] da_pay;
    bpc_div #(.W(DIV_W), .PW(58)) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_v),
        .i_num   (r2_ma),
        .i_den   (r2_mb),
        .i_pay   (r2_pay),
        .o_valid (da_v),
        .o_quo   (da_q),
        .o_pay   (da_pay)
    );

    // Stage 3: B5, saturated temperature and B6.
    logic [31:0] s3_x2, s3_b5, s3_t;
    logic [15:0] s3_tsat;
    assign s3_x2 = da_pay[25] ? (32'd0 - da_q) : da_q;
    assign s3_b5 = da_pay[57:26] + s3_x2;
    assign s3_t  = $unsigned($signed(s3_b5 + 32'd8) >>> 4);
    always_comb begin
        if ($signed(s3_t) > $signed(C_T_MAX)) begin
            s3_tsat = C_T_MAX[15:0];
        end else if ($signed(s3_t) < $signed(C_T_MIN)) begin
            s3_tsat = C_T_MIN[15:0];
        end else begin
            s3_tsat = s3_t[15:0];
        end
    end

    // Stage 7: B3 and the B4 factor.
    logic [31:0] s7_x3, s7_v, s7_x3p;
    assign s7_x3  = $unsigned($signed(r6_b2sq) >>> 11) + r6_x2a;
    assign s7_v   = (((ac1 << 2) + s7_x3) << r_oss) + 32'd2;
    assign s7_x3p = $unsigned($signed($unsigned($signed(r6_b1sq) >>> 16) + r6_x1c
                    + 32'd2) >>> 2);

    // Stage 10: form the pressure division.
    logic s10_err;
    assign s10_err = r9_err || (r9_b4 == 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
            r7_v  <= 1'b0;
            r8_v  <= 1'b0;
            r9_v  <= 1'b0;
            r10_v <= 1'b0;
        end else if (en) begin
            r3_v  <= da_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
            r7_v  <= r6_v;
            r8_v  <= r7_v;
            r9_v  <= r8_v;
            r10_v <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_b6    <= s3_b5 - C_T_OFFSET;
            r3_t     <= s3_tsat;
            r3_err   <= da_pay[24];
            r3_up    <= da_pay[23:0];

            r4_b6sq  <= r3_b6 * r3_b6;
            r4_ac2b6 <= ac2 * r3_b6;
            r4_ac3b6 <= ac3 * r3_b6;
            r4_t     <= r3_t;
            r4_err   <= r3_err;
            r4_up    <= r3_up;

            r5_sq    <= $unsigned($signed(r4_b6sq) >>> 12);
            r5_x2a   <= $unsigned($signed(r4_ac2b6) >>> 11);
            r5_x1c   <= $unsigned($signed(r4_ac3b6) >>> 13);
            r5_t     <= r4_t;
            r5_err   <= r4_err;
            r5_up    <= r4_up;

            r6_b2sq  <= b2c * r5_sq;
            r6_b1sq  <= b1c * r5_sq;
            r6_x2a   <= r5_x2a;
            r6_x1c   <= r5_x1c;
            r6_t     <= r5_t;
            r6_err   <= r5_err;
            r6_up    <= r5_up;

            // Truncating divide by four: bias negatives before the shift.
            r7_b3    <= $unsigned($signed(s7_v + (s7_v[31] ? 32'd3 : 32'd0)) >>> 2);
            r7_x3p   <= s7_x3p;
            r7_t     <= r6_t;
            r7_err   <= r6_err;
            r7_up    <= r6_up;

            r8_b4m   <= ac4 * (r7_x3p + C_HALF);
            r8_diff  <= {8'd0, r7_up} - r7_b3;
            r8_t     <= r7_t;
            r8_err   <= r7_err;

            r9_b4    <= r8_b4m >> 15;
            r9_b7    <= r8_diff * (C_P_SCALE >> r_oss);
            r9_t     <= r8_t;
            r9_err   <= r8_err;

            // Small B7 doubles before the divide, large B7 after it.
            r10_num  <= r9_b7[31] ? r9_b7 : (r9_b7 << 1);
            r10_den  <= r9_b4;
            r10_pay  <= {r9_t, s10_err, r9_b7[31]};
        end
    end

    // Pressure divider.
    logic        db_v;
    logic [31:0] db_q;
    logic [17:0] db_pay;
    bpc_div #(.W(DIV_W), .PW(18)) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_v),
        .i_num   (r10_num),
        .i_den   (r10_den),
        .i_pay   (r10_pay),
        .o_valid (db_v),
        .o_quo   (db_q),
        .o_pay   (db_pay)
    );

    // Stages 11 to 14: final pressure correction.
    logic        r11_v, r12_v, r13_v;
    logic [31:0] r11_p, r12_p, r13_p;
    logic [17:1] r11_pay, r12_pay, r13_pay;
    logic [31:0] r12_sq, r12_m2, r13_m3, r13_x2;
    logic [31:0] s12_a, s14_p;
    logic [OUT_W-1:0] r14_data;
    logic        r14_err;

    assign s12_a = $unsigned($signed(r11_p) >>> 8);
    assign s14_p = r13_p + $unsigned($signed($unsigned($signed(r13_m3) >>> 16)
                   + r13_x2 + C_K3) >>> 4);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
            r12_v <= 1'b0;
            r13_v <= 1'b0;
            r14_v <= 1'b0;
        end else if (en) begin
            r11_v <= db_v;
            r12_v <= r11_v;
            r13_v <= r12_v;
            r14_v <= r13_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_p    <= db_pay[0] ? (db_q << 1) : db_q;
            r11_pay  <= db_pay[17:1];
            r12_sq   <= s12_a * s12_a;
            r12_m2   <= C_K2 * r11_p;
            r12_p    <= r11_p;
            r12_pay  <= r11_pay;
            r13_m3   <= r12_sq * C_K1;
            r13_x2   <= $unsigned($signed(r12_m2) >>> 16);
            r13_p    <= r12_p;
            r13_pay  <= r12_pay;
            r14_err  <= r13_pay[1];
            r14_data <= r13_pay[1] ? '0 : {s14_p, r13_pay[17:2]};
        end
    end

    assign m_axis_tvalid = r14_v;
    assign m_axis_tdata  = r14_data;
    assign m_axis_tuser  = r14_err;

endmodule
`default_nettype wire

>>> rtl/bpc_check.sv
`timescale 1ns / 1ps
`default_nettype none
`include "barometric_pressure_compensation_assert.svh"
module bpc_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_m_tvalid,
    input logic                       i_m_tready,
    input logic [bpc_pkg::OUT_W-1:0]  i_m_tdata,
    input logic                       i_m_tuser,
    input logic                       i_pready
);
    import bpc_pkg::*;

    `BPC_ASSERT_ALWAYS(a_no_out_after_reset, i_clk, !i_rst_n |=> !i_m_tvalid, "result after reset")
    `BPC_ASSERT_RUN(a_err_zero, i_clk, i_rst_n, (i_m_tvalid && i_m_tuser) |-> (i_m_tdata == '0), "error result not zero")
    `BPC_ASSERT_RUN(a_pready, i_clk, i_rst_n, i_pready, "pready low")
    `BPC_ASSERT_RUN(a_out_hold, i_clk, i_rst_n, (i_m_tvalid && !i_m_tready) |=> i_m_tvalid, "result dropped")

endmodule

bind barometric_pressure_compensation bpc_check u_bpc_check (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_pready   (pready)
);
`default_nettype wire

>>> tb/tb_barometric_pressure_compensation.sv
`timescale 1ns / 1ps
// Checks the pressure compensation block against a local integer model of the
// datasheet arithmetic. Requests come from a queue at random pacing, results
// are compared in order against a queue of predicted readings.
module tb_barometric_pressure_compensation;
    import bpc_pkg::*;

    typedef struct packed {
        logic [15:0] temp_tenths;
        logic [31:0] pressure_pa;
        logic        div_err;
    } t_reading;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    barometric_pressure_compensation u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copies of the coefficient registers used by the predictor.
    logic [63:0] cal_a, cal_b;
    logic [31:0] cal_c;
    logic [1:0]  osr;

    logic [IN_W-1:0] pending_q[$];   // requests waiting to be driven
    t_reading        expected_q[$];  // predicted readings, oldest first
    int  errors;
    bit  calm;                       // no random idling while set
    bit  in_taken;                   // a request was accepted at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("[barometric_pressure_compensation] ERROR");
        $finish;
    end

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        return $unsigned($signed(v) >>> s);
    endfunction

    // Truncating signed divide on 32-bit patterns; the most negative value
    // divided by minus one wraps to itself.
    function automatic logic [31:0] sdiv(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic t_reading compensate(input logic [IN_W-1:0] req);
        t_reading r;
        logic [31:0] ut, up, ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        logic [31:0] x1, x2, x3, d, b5, b6, sq, b3, b4, b7, p, t;
        int s;
        s = osr;
        ut = {16'd0, req[15:0]};
        up = {8'd0, req[39:16]} >> (8 - s);
        ac1 = sx16(cal_a[63:48]); ac2 = sx16(cal_a[47:32]);
        ac3 = sx16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
        ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
        b1 = sx16(cal_b[31:16]); b2 = sx16(cal_b[15:0]);
        mc = sx16(cal_c[31:16]); md = sx16(cal_c[15:0]);
        r = '{temp_tenths: 16'd0, pressure_pa: 32'd0, div_err: 1'b1};
        x1 = asr((ut - ac6) * ac5, 15);
        d = x1 + md;
        if (d == 0) return r;
        x2 = sdiv(mc << 11, d);
        b5 = x1 + x2;
        t = asr(b5 + 32'd8, 4);
        if ($signed(t) < $signed(C_T_MIN)) t = C_T_MIN;
        else if ($signed(t) > $signed(C_T_MAX)) t = C_T_MAX;
        b6 = b5 - C_T_OFFSET;
        sq = asr(b6 * b6, 12);
        x1 = asr(b2 * sq, 11);
        x2 = asr(ac2 * b6, 11);
        x3 = x1 + x2;
        b3 = sdiv(((ac1 * 32'd4 + x3) << s) + 32'd2, 32'd4);
        x1 = asr(ac3 * b6, 13);
        x2 = asr(b1 * sq, 16);
        x3 = asr(x1 + x2 + 32'd2, 2);
        b4 = (ac4 * (x3 + C_HALF)) >> 15;
        if (b4 == 0) return r;
        b7 = (up - b3) * (C_P_SCALE >> s);
        if (!b7[31]) p = (b7 * 32'd2) / b4;
        else p = (b7 / b4) * 32'd2;
        x1 = asr(p, 8) * asr(p, 8);
        x1 = asr(x1 * C_K1, 16);
        x2 = asr(C_K2 * p, 16);
        p = p + asr(x1 + x2 + C_K3, 4);
        r = '{temp_tenths: t[15:0], pressure_pa: p, div_err: 1'b0};
        return r;
    endfunction

    // Request driver: presents queued requests with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            // The previous request (if any) was taken at the last rising edge.
            if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
                s_axis_tdata  <= pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Predict at acceptance so the prediction uses the live calibration.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_q.push_back(compensate(s_axis_tdata));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 26);
    end

    // Result monitor.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (m_axis_tdata[15:0] !== want.temp_tenths) begin
                    $error("temperature_tenths exp %0d got %0d",
                           $signed(want.temp_tenths), $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (m_axis_tdata[47:16] !== want.pressure_pa) begin
                    $error("pressure_pa exp %0d got %0d",
                           $signed(want.pressure_pa), $signed(m_axis_tdata[47:16]));
                    errors++;
                end
                if (m_axis_tuser !== want.div_err) begin
                    $error("divide_error exp %0b got %0b", want.div_err, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_COEF_A: cal_a = val;
            REG_COEF_B: cal_b = val;
            REG_COEF_C: cal_c = val[31:0];
            default:    osr = val[1:0];
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic load_cal(input logic [63:0] a, input logic [63:0] b,
                            input logic [31:0] c, input logic [1:0] o);
        apb_write(REG_COEF_A, a);
        apb_write(REG_COEF_B, b);
        apb_write(REG_COEF_C, {32'd0, c});
        apb_write(REG_OSS, {62'd0, o});
    endtask

    // Waits until every request is delivered and the pipeline has drained.
    task automatic drain;
        int guard;
        guard = 0;
        while ((pending_q.size() > 0 || s_axis_tvalid || expected_q.size() > 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (100) @(posedge i_clk);
    endtask

    // Reading near a typical sensor, with random spread; pressure is sometimes fully random.
    function automatic logic [IN_W-1:0] plausible_req;
        logic [15:0] ut;
        logic [23:0] up;
        ut = 16'd27898 + 16'($urandom_range(8000)) - 16'd4000;
        up = 24'($urandom_range(24'hFFFFFF));
        if ($urandom_range(3) != 0) up = 24'h5D0000 + 24'($urandom_range(24'h3FFFF));
        return {up, ut};
    endfunction

    // Typical factory calibration set.
    localparam logic [63:0] TYP_A = {16'd408, -16'sd72, -16'sd14383, 16'd32741};
    localparam logic [63:0] TYP_B = {16'd32757, 16'd23153, 16'd6190, 16'd4};
    localparam logic [31:0] TYP_C = {-16'sd8711, 16'd2868};

    initial begin
        errors = 0;
        calm = 1'b0;
        cal_a = '0; cal_b = '0; cal_c = '0; osr = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset all coefficients are zero, so every request divides by zero.
        pending_q.push_back('0);
        pending_q.push_back('1);
        drain();

        // Directed: datasheet example and field extremes at every oversampling.
        for (int o = 0; o < 4; o++) begin
            load_cal(TYP_A, TYP_B, TYP_C, 2'(o));
            pending_q.push_back({24'd23843 << (8 - o), 16'd27898});
            pending_q.push_back({24'hFFFFFF, 16'hFFFF});
            pending_q.push_back({24'h000000, 16'h0000});
            pending_q.push_back({24'h800000, 16'h8000});
            drain();
        end
        // Temperature divisor zero: ut equal to AC6 gives X1 = 0, MD = 0.
        load_cal(TYP_A, TYP_B, {-16'sd8711, 16'd0}, 2'd0);
        pending_q.push_back({24'h5D2300, TYP_B[47:32]});
        // Large MC with small divisor pushes the temperature into saturation.
        drain();
        load_cal(TYP_A, TYP_B, {16'h7FFF, 16'd1}, 2'd1);
        pending_q.push_back({24'h5D2300, TYP_B[47:32]});
        drain();
        load_cal(TYP_A, TYP_B, {16'h8000, 16'd1}, 2'd2);
        pending_q.push_back({24'h5D2300, TYP_B[47:32]});
        drain();
        // AC4 zero makes the pressure divisor zero.
        load_cal({TYP_A[63:16], 16'd0}, TYP_B, TYP_C, 2'd3);
        pending_q.push_back({24'h5D2300, 16'd27898});
        drain();
        // Coefficient extremes.
        load_cal('1, '1, '1, 2'd3);
        pending_q.push_back(plausible_req());
        pending_q.push_back('1);
        drain();
        load_cal({4{16'h8000}}, {4{16'h8000}}, {2{16'h8000}}, 2'd0);
        pending_q.push_back(plausible_req());
        pending_q.push_back('0);
        drain();

        // Random phases: mostly near-typical calibrations, some fully random.
        for (int ph = 0; ph < 10; ph++) begin
            logic [63:0] ra, rb;
            logic [31:0] rc;
            if (ph % 3 == 2) begin
                ra = {$urandom, $urandom}; rb = {$urandom, $urandom}; rc = $urandom;
            end else begin
                ra = TYP_A ^ {$urandom & 32'h00FF_00FF, $urandom & 32'h00FF_00FF};
                rb = TYP_B ^ {$urandom & 32'h00FF_00FF, $urandom & 32'h00FF_00FF};
                rc = TYP_C ^ ($urandom & 32'h00FF_00FF);
            end
            load_cal(ra, rb, rc, 2'($urandom_range(3)));
            calm = (ph == 4);
            for (int k = 0; k < 75; k++) begin
                if ($urandom_range(4) == 0)
                    pending_q.push_back({24'($urandom), 16'($urandom)});
                else
                    pending_q.push_back(plausible_req());
            end
            drain();
        end
        calm = 1'b0;

        // Every predicted reading must have been delivered.
        if (expected_q.size() != 0 || pending_q.size() != 0) begin
            $error("results missing: %0d predicted readings never arrived",
                   expected_q.size());
            errors++;
        end

        if (errors == 0) begin
            $display("[barometric_pressure_compensation] OK");
        end else begin
            $display("[barometric_pressure_compensation] ERROR");
        end
        $finish;
    end
endmodule
